// ----- src/nsv_pkg.sv -----
// Shared types and constants for the nearest-seed Voronoi labeler.
// Used by every module of the block but nsv_ram; no dependencies of its own.
package nsv_pkg;

   // Default configuration of the block.
   localparam int DEF_MAX_SEEDS    = 256;
   localparam int DEF_PALETTE_SIZE = 19;
   localparam int DEF_COORD_BITS   = 12;

   // Fixed widths of the beat fields.
   localparam int OP_W      = 2;
   localparam int FIELD_W   = 12;
   localparam int NEAREST_W = 8;
   localparam int COLOR_W   = 5;

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR    = 2'd0,
      OP_APPEND   = 2'd1,
      OP_CLASSIFY = 2'd2
   } op_type;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ----- src/nsv_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module nsv_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/nsv_scan_dp.sv -----
// Distance pipeline of the labeler: absolute differences, squares, sum and
// running minimum over the seeds read from the seed memory. Uses nsv_pkg.
module nsv_scan_dp #(
   parameter int COORD_BITS = 12,
   parameter int IDX_W      = 8,
   parameter int PAL_W      = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear_best,
   input  logic                    issue,
   input  logic [IDX_W-1:0]        issue_idx,
   input  logic [PAL_W-1:0]        issue_col,
   input  logic [COORD_BITS-1:0]   pixel_x,
   input  logic [COORD_BITS-1:0]   pixel_y,
   input  logic [2*COORD_BITS-1:0] rd_data,
   output logic                    busy,
   output logic [IDX_W-1:0]        best_idx,
   output logic [PAL_W-1:0]        best_col
);

   import nsv_pkg::*;

   localparam int SQ_W = 2 * COORD_BITS;
   localparam int D_W  = SQ_W + 1;

   // Stage 0 lines up with the memory read data.
   logic             v0_ff, v1_ff, v2_ff;
   logic [IDX_W-1:0] idx0_ff, idx1_ff, idx2_ff;
   logic [PAL_W-1:0] col0_ff, col1_ff, col2_ff;

   logic [COORD_BITS-1:0] seed_x, seed_y;
   logic [COORD_BITS-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic [SQ_W-1:0]       sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [D_W-1:0]        sum;
   logic                  take;

   logic             found_ff;
   logic [D_W-1:0]   best_d_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [PAL_W-1:0] best_col_ff;

   // Memory word holds the row in the upper half and the column below it.
   assign seed_x = rd_data[COORD_BITS-1:0];
   assign seed_y = rd_data[SQ_W-1:COORD_BITS];

   // Absolute coordinate differences.
   always_comb begin
      dx_in = (seed_x > pixel_x) ? seed_x - pixel_x : pixel_x - seed_x;
      dy_in = (seed_y > pixel_y) ? seed_y - pixel_y : pixel_y - seed_y;
   end

   // Squares, each followed by a register.
   assign sqx_in = SQ_W'(dx_ff) * SQ_W'(dx_ff);
   assign sqy_in = SQ_W'(dy_ff) * SQ_W'(dy_ff);

   // Squared distance and the strict-less compare that keeps the lower index on ties.
   assign sum  = D_W'(sqx_ff) + D_W'(sqy_ff);
   assign take = v2_ff && (!found_ff || (sum < best_d_ff));

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      idx0_ff <= issue_idx;
      col0_ff <= issue_col;
      idx1_ff <= idx0_ff;
      col1_ff <= col0_ff;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      idx2_ff <= idx1_ff;
      col2_ff <= col1_ff;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
   end

   // Running minimum; cleared when a new beat is taken so an empty scan gives zero.
   always_ff @(posedge clock) begin
      if (reset || clear_best) begin
         found_ff    <= 1'b0;
         best_idx_ff <= '0;
         best_col_ff <= '0;
      end else if (take) begin
         found_ff    <= 1'b1;
         best_idx_ff <= idx2_ff;
         best_col_ff <= col2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_d_ff <= sum;
      end
   end

   assign busy     = v0_ff | v1_ff | v2_ff;
   assign best_idx = best_idx_ff;
   assign best_col = best_col_ff;

endmodule

// ----- src/nearest_seed_voronoi_label.sv -----
// Nearest-seed Voronoi labeler: seed table in one RAM, brute-force scan.
// Depends on nsv_pkg, nsv_ram and nsv_scan_dp.
//
// Usage:
//   The request channel (req_*) carries one operation per beat. A clear beat
//   empties the seed table and the overflow flag and returns nothing. An append
//   beat stores one seed if there is room and returns a result beat with zero
//   indexes and the overflow flag. A classify beat returns the index of the
//   nearest stored seed (lowest index on ties, zero for an empty table), that
//   index modulo PALETTE_SIZE, and the flag. Operation code 3 is dropped.
//   Timing: a clear leaves req_ready high, so the next beat can follow in the
//   next cycle. Append goes to the done state, which loads the output register
//   and raises rsp_valid once the register is free. Classify reads one seed
//   per cycle through the single read port of the seed RAM, drains the
//   distance pipeline and then does the same; an empty table skips the scan.
//   req_ready rises together with rsp_valid.
//   The block works on one request at a time. A finished result sits in the
//   output register until rsp_ready takes it; a new request can be accepted
//   meanwhile, and its result waits until the register is free.
//   Reset empties the table and clears the overflow flag; the seed RAM itself
//   is not cleared, as only written entries are ever read.
module nearest_seed_voronoi_label #(
   parameter int MAX_SEEDS    = nsv_pkg::DEF_MAX_SEEDS,
   parameter int PALETTE_SIZE = nsv_pkg::DEF_PALETTE_SIZE,
   parameter int COORD_BITS   = nsv_pkg::DEF_COORD_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [nsv_pkg::OP_W-1:0]        req_op,
   input  logic [nsv_pkg::FIELD_W-1:0]     req_seed_x,
   input  logic [nsv_pkg::FIELD_W-1:0]     req_seed_y,
   input  logic [nsv_pkg::FIELD_W-1:0]     req_pixel_x,
   input  logic [nsv_pkg::FIELD_W-1:0]     req_pixel_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [nsv_pkg::NEAREST_W-1:0]   rsp_nearest_index,
   output logic [nsv_pkg::COLOR_W-1:0]     rsp_color_index,
   output logic                            rsp_table_full
);

   import nsv_pkg::*;

   localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int CNT_W = $clog2(MAX_SEEDS + 1);
   localparam int PAL_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int WORD_W = 2 * COORD_BITS;

   state_type state_ff, state_in;

   logic                  req_acc;
   logic                  is_clear, is_append, is_classify;
   logic                  table_has_room;
   logic                  ram_we, issue, rsp_load;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [IDX_W-1:0]      last_ff;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [PAL_W-1:0]      scol_ff, scol_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NEAREST_W-1:0]  rsp_idx_ff;
   logic [COLOR_W-1:0]    rsp_col_ff;
   logic                  rsp_full_ff;

   logic [WORD_W-1:0]     rd_data;
   logic                  dp_busy;
   logic [IDX_W-1:0]      best_idx;
   logic [PAL_W-1:0]      best_col;

   // Request decode.
   assign req_ready      = (state_ff == ST_IDLE);
   assign req_acc        = req_valid && req_ready;
   assign is_clear       = (req_op == OP_CLEAR);
   assign is_append      = (req_op == OP_APPEND);
   assign is_classify    = (req_op == OP_CLASSIFY);
   assign table_has_room = (count_ff < CNT_W'(MAX_SEEDS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && is_append) begin
               state_in = ST_DONE;
            end else if (req_acc && is_classify) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dp_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      ram_we   = 1'b0;
      issue    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE:  ram_we   = req_acc && is_append && table_has_room;
         ST_SCAN:  issue    = 1'b1;
         ST_DRAIN: issue    = 1'b0;
         ST_DONE:  rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Table fill count and sticky overflow flag.
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (req_acc && is_clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (ram_we) begin
         count_in = count_ff + CNT_W'(1);
      end else if (req_acc && is_append) begin
         ovf_in = 1'b1;
      end
   end

   // Scan address and its color index, which wraps at the palette size.
   always_comb begin
      scan_in = scan_ff;
      scol_in = scol_ff;
      if (req_acc) begin
         scan_in = '0;
         scol_in = '0;
      end else if (issue) begin
         scan_in = scan_ff + IDX_W'(1);
         scol_in = (scol_ff == PAL_W'(PALETTE_SIZE - 1)) ? '0 : scol_ff + PAL_W'(1);
      end
   end

   // Output register handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan and result payload registers.
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      scol_ff <= scol_in;
      if (req_acc && is_classify) begin
         px_ff   <= COORD_BITS'(req_pixel_x);
         py_ff   <= COORD_BITS'(req_pixel_y);
         last_ff <= IDX_W'(count_ff - CNT_W'(1));
      end
      if (rsp_load) begin
         rsp_idx_ff  <= NEAREST_W'(best_idx);
         rsp_col_ff  <= COLOR_W'(best_col);
         rsp_full_ff <= ovf_ff;
      end
   end

   // Seed memory: row and column packed into one word.
   nsv_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_SEEDS)
   ) u_seed_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IDX_W'(count_ff)),
      .wr_data ({COORD_BITS'(req_seed_y), COORD_BITS'(req_seed_x)}),
      .rd_en   (issue),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   // Distance pipeline and running minimum.
   nsv_scan_dp #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .PAL_W      (PAL_W)
   ) u_scan_dp (
      .clock      (clock),
      .reset      (reset),
      .clear_best (req_acc),
      .issue      (issue),
      .issue_idx  (scan_ff),
      .issue_col  (scol_ff),
      .pixel_x    (px_ff),
      .pixel_y    (py_ff),
      .rd_data    (rd_data),
      .busy       (dp_busy),
      .best_idx   (best_idx),
      .best_col   (best_col)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_idx_ff;
   assign rsp_color_index   = rsp_col_ff;
   assign rsp_table_full    = rsp_full_ff;

endmodule

// ----- src/nsv_checker.sv -----
// Port-level checker for the nearest-seed Voronoi labeler, bound to the top.
// Depends on nsv_pkg and nearest_seed_voronoi_label.
module nsv_checker #(
   parameter int PALETTE_SIZE = nsv_pkg::DEF_PALETTE_SIZE
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [nsv_pkg::OP_W-1:0]      req_op,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [nsv_pkg::NEAREST_W-1:0] rsp_nearest_index,
   input logic [nsv_pkg::COLOR_W-1:0]   rsp_color_index,
   input logic                          rsp_table_full
);

   import nsv_pkg::*;

   // A stalled result beat stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_nearest_index)
         && $stable(rsp_color_index) && $stable(rsp_table_full))
      else $error("result payload changed while stalled");

   // The color index never reaches the palette size.
   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_color_index < PALETTE_SIZE))
      else $error("color index out of palette range");

   // Append and classify take the block out of the idle state, so req_ready drops once they are accepted.
   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_APPEND || req_op == OP_CLASSIFY)
         |=> !req_ready)
      else $error("request taken while previous one still in progress");

   // A clear leaves req_ready high in the cycle after it is accepted.
   a_clear_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_CLEAR) |=> req_ready)
      else $error("clear did not complete in one cycle");

endmodule

bind nearest_seed_voronoi_label nsv_checker #(
   .PALETTE_SIZE (PALETTE_SIZE)
) u_nsv_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_op            (req_op),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_nearest_index (rsp_nearest_index),
   .rsp_color_index   (rsp_color_index),
   .rsp_table_full    (rsp_table_full)
);

// ----- verif/nearest_seed_voronoi_label_tb.sv -----
// Self-checking testbench for nearest_seed_voronoi_label: seed table loads, clears,
// nearest-seed classification, tie breaking, table overflow and output back-pressure.
// Depends on nsv_pkg and the nearest_seed_voronoi_label RTL only.
module nearest_seed_voronoi_label_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nsv_pkg::*;

   // Operation code that the block must drop without a result.
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
   localparam logic [FIELD_W-1:0] COORD_MASK = FIELD_W'((1 << DEF_COORD_BITS) - 1);
   localparam logic [FIELD_W-1:0] COORD_TOP = COORD_MASK;
   localparam int ITEMS_TARGET = 850;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [NEAREST_W-1:0] nearest;
      logic [COLOR_W-1:0]   color;
      logic                 full;
   } label_beat_type;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op;
   logic [FIELD_W-1:0]   req_seed_x;
   logic [FIELD_W-1:0]   req_seed_y;
   logic [FIELD_W-1:0]   req_pixel_x;
   logic [FIELD_W-1:0]   req_pixel_y;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [NEAREST_W-1:0] rsp_nearest_index;
   logic [COLOR_W-1:0]   rsp_color_index;
   logic                 rsp_table_full;

   // Shadow copy of the seed table used to predict labels.
   logic [DEF_COORD_BITS-1:0] seed_col_mem [DEF_MAX_SEEDS];
   logic [DEF_COORD_BITS-1:0] seed_row_mem [DEF_MAX_SEEDS];
   int unsigned seeds_held = 0;
   bit          overflow_seen = 1'b0;

   // Labels waiting for their result beat, oldest first.
   label_beat_type expected_labels [$];

   // Pacing controls shared by the tests, the sender and the receiver.
   int          sender_gap_max = 0;
   int          burst_left = 0;
   rx_mode_type rsp_stall_mode = RX_ALWAYS;
   int          rsp_hold_cycles = 0;
   logic [7:0]  rx_pattern = 8'b1101_0110;

   // Run statistics.
   int items_sent = 0;
   int clears_sent = 0;
   int appends_sent = 0;
   int classifies_sent = 0;
   int reserved_sent = 0;
   int dropped_appends = 0;
   int largest_table = 0;
   int results_checked = 0;
   int mismatch_count = 0;

   nearest_seed_voronoi_label u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_seed_x        (req_seed_x),
      .req_seed_y        (req_seed_y),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_color_index   (rsp_color_index),
      .rsp_table_full    (rsp_table_full)
   );

   always #5 clock = ~clock;

   // Apply one request beat to the shadow table and work out its label, if it has one.
   function automatic void predict_label(input logic [OP_W-1:0] op,
                                         input logic [FIELD_W-1:0] sx,
                                         input logic [FIELD_W-1:0] sy,
                                         input logic [FIELD_W-1:0] px,
                                         input logic [FIELD_W-1:0] py,
                                         output bit gives_beat,
                                         output label_beat_type beat);
      longint unsigned best_dist;
      longint unsigned cand_dist;
      longint dx;
      longint dy;
      int unsigned best_slot;
      gives_beat = 1'b0;
      beat = '0;
      best_dist = 0;
      best_slot = 0;
      case (op)
         OP_CLEAR: begin
            seeds_held = 0;
            overflow_seen = 1'b0;
         end
         OP_APPEND: begin
            if (seeds_held < DEF_MAX_SEEDS) begin
               seed_col_mem[seeds_held] = DEF_COORD_BITS'(sx & COORD_MASK);
               seed_row_mem[seeds_held] = DEF_COORD_BITS'(sy & COORD_MASK);
               seeds_held++;
               if (seeds_held > largest_table) largest_table = seeds_held;
            end else begin
               overflow_seen = 1'b1;
               dropped_appends++;
            end
            gives_beat = 1'b1;
            beat.full = overflow_seen;
         end
         OP_CLASSIFY: begin
            // Scan in slot order; only a strictly smaller distance moves the winner.
            for (int unsigned i = 0; i < seeds_held; i++) begin
               dx = longint'(seed_col_mem[i]) - longint'(px & COORD_MASK);
               dy = longint'(seed_row_mem[i]) - longint'(py & COORD_MASK);
               cand_dist = longint'(dx * dx + dy * dy);
               if (i == 0 || cand_dist < best_dist) begin
                  best_dist = cand_dist;
                  best_slot = i;
               end
            end
            gives_beat = 1'b1;
            beat.nearest = NEAREST_W'(best_slot);
            beat.color = COLOR_W'(best_slot % DEF_PALETTE_SIZE);
            beat.full = overflow_seen;
         end
         default: ;
      endcase
   endfunction

   // A pixel a few steps away from a given coordinate, kept on the grid.
   function automatic logic [FIELD_W-1:0] nudge(input logic [FIELD_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > int'(COORD_TOP)) v = int'(COORD_TOP);
      return FIELD_W'(v);
   endfunction

   // Drop valid for a number of cycles and scramble the idle payload.
   task automatic idle_request(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         req_op <= OP_W'($urandom);
         req_seed_x <= FIELD_W'($urandom);
         req_seed_y <= FIELD_W'($urandom);
         req_pixel_x <= FIELD_W'($urandom);
         req_pixel_y <= FIELD_W'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Offer one request beat, hold it until accepted, then record its label.
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [FIELD_W-1:0] sx, input logic [FIELD_W-1:0] sy,
                               input logic [FIELD_W-1:0] px, input logic [FIELD_W-1:0] py);
      bit             gives_beat;
      label_beat_type beat;
      req_valid <= 1'b1;
      req_op <= op;
      req_seed_x <= sx;
      req_seed_y <= sy;
      req_pixel_x <= px;
      req_pixel_y <= py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_label(op, sx, sy, px, py, gives_beat, beat);
      if (gives_beat) expected_labels.push_back(beat);
      case (op)
         OP_CLEAR:    clears_sent++;
         OP_APPEND:   appends_sent++;
         OP_CLASSIFY: classifies_sent++;
         default:     reserved_sent++;
      endcase
      if (op != OP_RESERVED) items_sent++;
      // Bursts of random length separated by random gaps.
      if (sender_gap_max > 0) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 10);
            idle_request($urandom_range(1, sender_gap_max));
         end
      end
   endtask

   task automatic send_append(input logic [FIELD_W-1:0] sx, input logic [FIELD_W-1:0] sy);
      send_request(OP_APPEND, sx, sy, FIELD_W'($urandom), FIELD_W'($urandom));
   endtask

   task automatic send_classify(input logic [FIELD_W-1:0] px, input logic [FIELD_W-1:0] py);
      send_request(OP_CLASSIFY, FIELD_W'($urandom), FIELD_W'($urandom), px, py);
   endtask

   task automatic send_clear();
      send_request(OP_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom),
                   FIELD_W'($urandom), FIELD_W'($urandom));
   endtask

   // Classify a pixel next to a stored seed, or anywhere when the table is empty.
   task automatic send_near_classify();
      int unsigned slot;
      if (seeds_held == 0) begin
         send_classify(FIELD_W'($urandom), FIELD_W'($urandom));
      end else begin
         slot = $urandom_range(0, seeds_held - 1);
         send_classify(nudge(FIELD_W'(seed_col_mem[slot])), nudge(FIELD_W'(seed_row_mem[slot])));
      end
   endtask

   // Stop offering and wait until every predicted label has been seen.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_labels.size() != 0);
   endtask

   // Corners of the grid, ties, duplicates, the empty table and the dropped op code.
   task automatic test_directed_cases();
      sender_gap_max = 0;
      rsp_stall_mode = RX_RANDOM;
      send_classify(COORD_TOP, 12'd0);
      send_request(OP_RESERVED, 12'd0, 12'd0, 12'd0, 12'd0);
      send_append(12'd0, 12'd0);
      send_append(COORD_TOP, COORD_TOP);
      send_classify(12'd0, 12'd0);
      send_classify(COORD_TOP, COORD_TOP);
      send_classify(12'd2048, 12'd2048);
      // Equal distance to both seeds: the lower slot wins.
      send_classify(12'd2047, 12'd2048);
      // A duplicate seed never beats the first copy.
      send_append(COORD_TOP, COORD_TOP);
      send_classify(COORD_TOP, COORD_TOP);
      send_append(12'd0, COORD_TOP);
      send_append(COORD_TOP, 12'd0);
      send_classify(COORD_TOP, 12'd0);
      send_classify(12'd0, COORD_TOP);
      send_classify(12'd1000, 12'd3000);
      send_clear();
      send_classify(12'd100, 12'd100);
      send_request(OP_RESERVED, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
      send_append(COORD_TOP, 12'd0);
      send_classify(12'd0, COORD_TOP);
   endtask

   // Fill all slots, append past the end, query chosen slots and random pixels, then clear the flag.
   task automatic test_table_overflow();
      int unsigned probe [6];
      probe = '{255, 254, 246, 18, 0, 128};
      sender_gap_max = 4;
      rsp_stall_mode = RX_PATTERN;
      send_clear();
      for (int i = 0; i < DEF_MAX_SEEDS; i++)
         send_append(FIELD_W'($urandom), FIELD_W'($urandom));
      rsp_stall_mode = RX_RANDOM;
      for (int i = 0; i < 3; i++)
         send_append(FIELD_W'($urandom), FIELD_W'($urandom));
      foreach (probe[i])
         send_classify(FIELD_W'(seed_col_mem[probe[i]]), FIELD_W'(seed_row_mem[probe[i]]));
      for (int i = 0; i < 4; i++)
         send_classify(FIELD_W'($urandom), FIELD_W'($urandom));
      send_clear();
      send_classify(FIELD_W'($urandom), FIELD_W'($urandom));
      send_append(FIELD_W'($urandom), FIELD_W'($urandom));
   endtask

   // Hold the output off for a long stretch while requests keep coming.
   task automatic test_output_hold_off();
      sender_gap_max = 0;
      rsp_stall_mode = RX_ALWAYS;
      send_clear();
      for (int i = 0; i < 4; i++)
         send_append(FIELD_W'($urandom), FIELD_W'($urandom));
      wait_results_drained();
      rsp_hold_cycles = 400;
      for (int i = 0; i < 10; i++)
         send_near_classify();
      send_append(FIELD_W'($urandom), FIELD_W'($urandom));
      send_classify(FIELD_W'($urandom), FIELD_W'($urandom));
   endtask

   // Mostly well-formed load-then-query sequences with random content, plus noise.
   task automatic test_random_sequences();
      int roll;
      int seed_run;
      int query_run;
      while (items_sent < ITEMS_TARGET) begin
         case ($urandom_range(0, 2))
            0:       sender_gap_max = 0;
            1:       sender_gap_max = 3;
            default: sender_gap_max = 12;
         endcase
         rsp_stall_mode = rx_mode_type'($urandom_range(0, 2));
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            if ($urandom_range(0, 99) < 85) send_clear();
            seed_run = ($urandom_range(0, 99) < 5) ? $urandom_range(40, 90)
                                                   : $urandom_range(0, 12);
            for (int i = 0; i < seed_run; i++)
               send_append(FIELD_W'($urandom), FIELD_W'($urandom));
            query_run = $urandom_range(2, 8);
            for (int i = 0; i < query_run; i++) begin
               if ($urandom_range(0, 99) < 10)
                  send_request(OP_RESERVED, FIELD_W'($urandom), FIELD_W'($urandom),
                               FIELD_W'($urandom), FIELD_W'($urandom));
               if ($urandom_range(0, 99) < 5) send_clear();
               if ($urandom_range(0, 99) < 60) send_near_classify();
               else send_classify(FIELD_W'($urandom), FIELD_W'($urandom));
            end
         end else begin
            for (int i = 0; i < $urandom_range(4, 8); i++)
               send_request(OP_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                            FIELD_W'($urandom), FIELD_W'($urandom));
         end
      end
   endtask

   // Receiver: long hold-offs first, otherwise the stall pattern of the current mode.
   always @(posedge clock) begin
      if (rsp_hold_cycles != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         case (rsp_stall_mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= ($urandom_range(0, 99) >= 35);
            default: begin
               rsp_ready <= rx_pattern[0];
               rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
            end
         endcase
      end
   end

   // Compare each accepted result beat with the oldest predicted label.
   always @(posedge clock) begin : check_result
      label_beat_type want;
      label_beat_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{nearest: rsp_nearest_index, color: rsp_color_index, full: rsp_table_full};
         if (expected_labels.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: result beat with no label pending: nearest %0d color %0d %s %0b",
                        $time, got.nearest, got.color, "full", got.full);
            mismatch_count++;
         end else begin
            want = expected_labels.pop_front();
            results_checked++;
            if (got.nearest !== want.nearest || got.color !== want.color ||
                got.full !== want.full) begin
               if (mismatch_count < MAX_REPORTS)
                  $display({"%0t: label mismatch: expected nearest %0d color %0d full %0b,",
                            " got nearest %0d color %0d full %0b"},
                           $time, want.nearest, want.color, want.full,
                           got.nearest, got.color, got.full);
               mismatch_count++;
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("Timeout: %0d labels still pending", expected_labels.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_CLEAR;
      req_seed_x = '0;
      req_seed_y = '0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      wait_results_drained();
      test_table_overflow();
      wait_results_drained();
      test_output_hold_off();
      wait_results_drained();
      test_random_sequences();
      wait_results_drained();

      // Leave room for any stray beat after the longest scan.
      repeat (DEF_MAX_SEEDS + 50) @(posedge clock);
      if (expected_labels.size() != 0) mismatch_count++;

      $display("Sent %0d beats: %0d clears, %0d appends (%0d dropped), %0d classifies, %0d %s",
               items_sent + reserved_sent, clears_sent, appends_sent, dropped_appends,
               classifies_sent, reserved_sent, "reserved.");
      $display("Checked %0d result beats, largest table %0d seeds, %0d mismatches.",
               results_checked, largest_table, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/nsv_pkg.sv
src/nsv_ram.sv
src/nsv_scan_dp.sv
src/nearest_seed_voronoi_label.sv
src/nsv_checker.sv
verif/nearest_seed_voronoi_label_tb.sv
